// ===== rtl/assert_macros.svh =====
// Assertion macros for the file that carries concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

// ===== rtl/vgwq_pkg.sv =====
// Types, constants and codes of the version-gated wait queue
package vgwq_pkg;

    localparam int DEPTH   = 16;
    localparam int MAX_OUT = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OUT_W   = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;

    typedef enum logic [1:0] {
        K_ADD     = 2'd0,
        K_REL     = 2'd1,
        K_REL_ALL = 2'd2,
        K_NONE    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_INVALID  = 2'd1,
        ST_FULL     = 2'd2,
        ST_RELEASED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_REL
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [30:0] target_seq;
        logic [30:0] current_version;
        logic [15:0] waiter_tag;
    } t_in_word;

    typedef struct packed {
        t_status     status;
        logic [15:0] released_tag;
        logic [30:0] released_target;
        logic        last;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic add_exec;
        logic pop;
        logic last;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_kind            kind;
        logic             rel_avail;
        logic             rel_next;
        logic [CNT_W-1:0] count;
    } t_dp_status;

endpackage

// ===== rtl/vgwq_ctrl.sv =====
// Controller: sequences decode, insertion and the release loop
module vgwq_ctrl
    import vgwq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_dp_status i_st,
    output logic       busy,
    output t_dp_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [OUT_W-1:0] r_n_out, n_n_out;

    // State and release counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_n_out <= '0;
        end else begin
            r_state <= n_state;
            r_n_out <= n_n_out;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DECODE;
            end
            S_DECODE: begin
                case (i_st.kind)
                    K_ADD:     n_state = S_IDLE;
                    K_REL:     n_state = S_REL;
                    K_REL_ALL: n_state = S_REL;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_REL: begin
                if (!o_cmd.pop || o_cmd.last) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        busy           = (r_state != S_IDLE);
        o_cmd.load     = (r_state == S_IDLE) && start;
        o_cmd.add_exec = (r_state == S_DECODE) && (i_st.kind == K_ADD);
        o_cmd.pop      = (r_state == S_REL) && i_st.rel_avail;
        // last word when the next head will not go, or the per-item bound is met
        o_cmd.last     = !i_st.rel_next || (r_n_out == OUT_W'(MAX_OUT - 1));
        n_n_out        = r_n_out;
        if (o_cmd.load)     n_n_out = '0;
        else if (o_cmd.pop) n_n_out = r_n_out + 1'b1;
    end

endmodule

// ===== rtl/vgwq_datapath.sv =====
// Datapath: sorted shift-register table, request register and result register
module vgwq_datapath
    import vgwq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_word   i_in,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_st,
    output logic       o_strobe,
    output t_out_word  o_res
);

    t_in_word         r_req;
    logic [CNT_W-1:0] r_count;
    logic [30:0]      r_tgt [DEPTH];
    logic [15:0]      r_tag [DEPTH];
    t_out_word        r_res;
    logic             r_strobe;

    logic             add_invalid;
    logic             add_full;
    logic             rel_all;
    logic             do_insert;
    logic [DEPTH-1:0] ins;
    logic [DEPTH-1:0] sh;

    // Per-entry compare against the new target: entries above it move up one
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            ins[i] = (CNT_W'(i) < r_count) && (r_tgt[i] > r_req.target_seq);
        end
        sh[0] = 1'b0;
        for (int i = 1; i < DEPTH; i++) begin
            sh[i] = ins[i-1];
        end
    end

    // Decisions reported to the controller
    always_comb begin
        add_invalid    = (r_req.target_seq <= r_req.current_version);
        add_full       = (r_count == CNT_W'(DEPTH));
        rel_all        = (r_req.kind == K_REL_ALL);
        do_insert      = i_cmd.add_exec && !add_invalid && !add_full;
        o_st.kind      = r_req.kind;
        o_st.count     = r_count;
        o_st.rel_avail = (r_count != '0) &&
                         (rel_all || (r_tgt[0] <= r_req.current_version));
        o_st.rel_next  = (r_count >= CNT_W'(2)) &&
                         (rel_all || (r_tgt[1] <= r_req.current_version));
    end

    // Request word latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_in;
    end

    // Table: insert in place or pop the head
    always_ff @(posedge i_clk) begin
        if (do_insert) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (sh[i]) begin
                    // entry 0 never shifts in; the index is held in range
                    r_tgt[i] <= r_tgt[(i > 0) ? i - 1 : 0];
                    r_tag[i] <= r_tag[(i > 0) ? i - 1 : 0];
                end else if (ins[i] || (CNT_W'(i) == r_count)) begin
                    r_tgt[i] <= r_req.target_seq;
                    r_tag[i] <= r_req.waiter_tag;
                end
            end
        end else if (i_cmd.pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                r_tgt[i] <= r_tgt[i+1];
                r_tag[i] <= r_tag[i+1];
            end
        end
    end

    // Fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (do_insert) begin
            r_count <= r_count + 1'b1;
        end else if (i_cmd.pop) begin
            r_count <= r_count - 1'b1;
        end
    end

    // Result word and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.add_exec || i_cmd.pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_exec) begin
            if (add_invalid)   r_res.status <= ST_INVALID;
            else if (add_full) r_res.status <= ST_FULL;
            else               r_res.status <= ST_ACCEPTED;
            r_res.released_tag    <= '0;
            r_res.released_target <= '0;
            r_res.last            <= 1'b1;
        end else if (i_cmd.pop) begin
            r_res.status          <= ST_RELEASED;
            r_res.released_tag    <= r_tag[0];
            r_res.released_target <= r_tgt[0];
            r_res.last            <= i_cmd.last;
        end
    end

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule

// ===== rtl/version_gated_wait_queue.sv =====
// Top level of the version-gated wait queue
//
// Waiters sit in a 16-entry table kept sorted by target version in a shift
// register, equal targets in arrival order. A command word is taken when start
// is high and busy is low. An add gives one result word through decode and then
// the result register, with busy high for one cycle, so the next word can be
// taken on the edge that takes the add result. A release or release-all gives
// one word per cycle from the head of the table, the first word passing decode,
// the first pop and the result register, and the block stays busy through decode
// and one pop per released waiter. A release that frees nothing gives no word
// and drops busy after decode and the release state. Each result word is
// on o_res for one cycle only, flagged by o_strobe, and must be taken then: there
// is no stall from the receiving side. last marks the final word of each command.
// Kind 3 is ignored and keeps busy high for one cycle.
`include "assert_macros.svh"

module version_gated_wait_queue
    import vgwq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_word  i_in,
    output logic      busy,
    output logic      o_strobe,
    output t_out_word o_res
);

    t_dp_cmd    cmd;
    t_dp_status st;

    // Sequencer
    vgwq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_st    (st),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // Table and result path
    vgwq_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cmd    (cmd),
        .o_st     (st),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    // Checks
    `ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, st.count > CNT_W'(DEPTH), "fill count overflow")
    `ASSERT_CLK(a_pop_valid, i_clk, i_rst_n, cmd.pop |-> (st.count != '0), "pop on empty table")
    `ASSERT_CLK(a_strobe_after_busy, i_clk, i_rst_n, o_strobe |-> $past(busy), "word without work")
    `ASSERT_CLK(a_release_continues, i_clk, i_rst_n, (o_strobe && (o_res.status == ST_RELEASED) && !o_res.last) |-> busy, "release stopped early")

endmodule

// ===== sim/tb_version_gated_wait_queue.sv =====
// Self-checking testbench for the version-gated wait queue
module tb_version_gated_wait_queue
    import vgwq_pkg::*;
();

    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 160;
    localparam int MAX_SHOWN = 10;

    // Predicted waiter table and the result words it still owes
    class waiter_table_model;
        logic [30:0] targets [DEPTH];
        logic [15:0] tags [DEPTH];
        int unsigned count;
        t_out_word   due_words [$];
        int unsigned mismatches;

        function new();
            count = 0;
            mismatches = 0;
        endfunction

        function void push_word(t_status st, logic [15:0] tag, logic [30:0] tgt, logic lst);
            t_out_word w;
            w.status = st;
            w.released_tag = tag;
            w.released_target = tgt;
            w.last = lst;
            due_words.push_back(w);
        endfunction

        // Update the table for one accepted command word
        function void note_command(t_in_word cmd);
            int unsigned pos;
            int unsigned n;
            case (cmd.kind)
                K_ADD: begin
                    // target test comes before the full test
                    if (cmd.target_seq <= cmd.current_version) begin
                        push_word(ST_INVALID, '0, '0, 1'b1);
                    end else if (count >= DEPTH) begin
                        push_word(ST_FULL, '0, '0, 1'b1);
                    end else begin
                        pos = 0;
                        while (pos < count && targets[pos] <= cmd.target_seq) pos++;
                        for (int i = count; i > pos; i--) begin
                            targets[i] = targets[i-1];
                            tags[i] = tags[i-1];
                        end
                        targets[pos] = cmd.target_seq;
                        tags[pos] = cmd.waiter_tag;
                        count++;
                        push_word(ST_ACCEPTED, '0, '0, 1'b1);
                    end
                end
                K_REL, K_REL_ALL: begin
                    n = 0;
                    while (n < count && n < MAX_OUT &&
                           (cmd.kind == K_REL_ALL || targets[n] <= cmd.current_version))
                        n++;
                    for (int i = 0; i < n; i++)
                        push_word(ST_RELEASED, tags[i], targets[i], i == n - 1);
                    for (int i = n; i < count; i++) begin
                        targets[i-n] = targets[i];
                        tags[i-n] = tags[i];
                    end
                    count -= n;
                end
                default: ;
            endcase
        endfunction

        // Compare one result word against the oldest one owed
        function void check_word(t_out_word got);
            t_out_word want;
            if (due_words.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected word: status %0d tag %h target %h last %b",
                             got.status, got.released_tag, got.released_target, got.last);
            end else begin
                want = due_words.pop_front();
                if (got.status !== want.status || got.released_tag !== want.released_tag ||
                    got.released_target !== want.released_target || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("word mismatch: exp %0d/%h/%h/%b got %0d/%h/%h/%b",
                                 want.status, want.released_tag, want.released_target,
                                 want.last, got.status, got.released_tag,
                                 got.released_target, got.last);
                end
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_word  i_in = '0;
    logic      busy;
    logic      o_strobe;
    t_out_word o_res;

    waiter_table_model book = new();
    int  idle_cycles = 0;
    bit  no_gaps = 0;
    logic [30:0] now_ver;

    version_gated_wait_queue uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_in     (i_in),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    always #5 i_clk = ~i_clk;

    // Result words are taken on the edge that ends their cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) book.check_word(o_res);
    end

    // Watchdog on cycles where no word moves either way
    always @(posedge i_clk) begin
        if (!i_rst_n || o_strobe || (start && !busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in_word make_cmd(t_kind k, logic [30:0] tgt, logic [30:0] cur,
                                          logic [15:0] tag);
        t_in_word w;
        w.kind = k;
        w.target_seq = tgt;
        w.current_version = cur;
        w.waiter_tag = tag;
        return w;
    endfunction

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 9);
    endfunction

    // Present one command word, hold until taken, then idle for the given gap when it is nonzero
    task automatic send_item(t_in_word w, int gap);
        start <= 1'b1;
        i_in <= w;
        do @(posedge i_clk); while (busy);
        book.note_command(w);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic add_waiter(logic [30:0] tgt, logic [30:0] cur, logic [15:0] tag);
        send_item(make_cmd(K_ADD, tgt, cur, tag), draw_gap());
    endtask

    initial begin
        int done;
        int choice;
        logic [30:0] tgt;
        t_in_word w;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-table releases, ignored kind, invalid targets
        send_item(make_cmd(K_REL_ALL, '0, '0, '0), draw_gap());
        send_item(make_cmd(K_REL, '1, '1, '1), draw_gap());
        send_item(make_cmd(K_NONE, '1, '0, '1), draw_gap());
        add_waiter('0, '0, 16'h1234);
        add_waiter('1, '1, 16'hffff);
        add_waiter(31'h7fff_fffe, '1, 16'h0001);
        // Extremes of target and tag
        add_waiter('1, '0, 16'hffff);
        add_waiter(31'd1, '0, 16'h0000);
        // Equal targets must leave in arrival order
        add_waiter(31'd100, 31'd5, 16'haaaa);
        add_waiter(31'd100, 31'd5, 16'hbbbb);
        add_waiter(31'd100, 31'd5, 16'hcccc);
        // Nothing reached yet on a non-empty table
        send_item(make_cmd(K_REL, '0, '0, '0), draw_gap());
        // Fill the table to the brim
        for (int i = 0; i < 11; i++)
            add_waiter(31'd50 + 31'(i * 20), 31'd10, 16'(i + 16'h0a00));
        // Full table, then invalid before full
        add_waiter(31'd60, 31'd10, 16'hdead);
        add_waiter(31'd10, 31'd10, 16'hbeef);
        send_item(make_cmd(K_REL, '0, 31'd100, '0), draw_gap());
        send_item(make_cmd(K_REL_ALL, '0, '0, '0), draw_gap());

        // Random: mostly well-formed traffic around a rising version
        now_ver = $urandom_range(0, 1000);
        done = 0;
        while (done < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) no_gaps = !no_gaps;
            if (done == RANDOM_ITEMS / 2) begin
                // hold off until every owed word has come, then jump near the top
                send_item(make_cmd(K_REL, '0, now_ver, '0), 1);
                while (book.due_words.size() != 0) @(posedge i_clk);
                now_ver = 31'h7fff_0000 + 31'($urandom_range(0, 1000));
                done++;
                continue;
            end
            choice = $urandom_range(0, 99);
            if (choice < 52) begin
                tgt = now_ver + 31'($urandom_range(1, 40));
                w = make_cmd(K_ADD, tgt, now_ver, 16'($urandom));
            end else if (choice < 60) begin
                tgt = now_ver - 31'($urandom_range(0, now_ver < 50 ? now_ver : 50));
                w = make_cmd(K_ADD, tgt, now_ver, 16'($urandom));
            end else if (choice < 82) begin
                now_ver = now_ver + 31'($urandom_range(0, 30));
                w = make_cmd(K_REL, 31'($urandom), now_ver, 16'($urandom));
            end else if (choice < 87) begin
                w = make_cmd(K_REL_ALL, 31'($urandom), 31'($urandom), 16'($urandom));
            end else begin
                // noise: any kind, any field value
                w = make_cmd(t_kind'($urandom_range(0, 3)), 31'($urandom), 31'($urandom),
                             16'($urandom));
            end
            send_item(w, draw_gap());
            if (w.kind != K_NONE) done++;
        end

        // Drain
        if (start) send_item(make_cmd(K_NONE, '0, '0, '0), 1);
        while (book.due_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (book.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== version_gated_wait_queue.f =====
+incdir+rtl
rtl/vgwq_pkg.sv
rtl/vgwq_ctrl.sv
rtl/vgwq_datapath.sv
rtl/version_gated_wait_queue.sv
sim/tb_version_gated_wait_queue.sv
